// File: hw/rtl/taf_pkg.sv
`default_nettype none
package taf_pkg;

  localparam int unsigned InTdataW = 72;   // cmd 5 + a 32 + b 32, padded to bytes
  localparam int unsigned OutTdataW = 40;  // result 32 + 4 flags, padded to bytes

  typedef enum logic [4:0] {
    CMD_LSL      = 5'd0,
    CMD_LSR      = 5'd1,
    CMD_ASR      = 5'd2,
    CMD_ROR      = 5'd3,
    CMD_AND      = 5'd4,
    CMD_EOR      = 5'd5,
    CMD_ORR      = 5'd6,
    CMD_BIC      = 5'd7,
    CMD_MVN      = 5'd8,
    CMD_MOV      = 5'd9,
    CMD_ADD      = 5'd10,
    CMD_SUB      = 5'd11,
    CMD_ADC      = 5'd12,
    CMD_SBC      = 5'd13,
    CMD_NEG      = 5'd14,
    CMD_MUL      = 5'd15,
    CMD_REV      = 5'd16,
    CMD_REV16    = 5'd17,
    CMD_REVSH    = 5'd18,
    CMD_SXTH     = 5'd19,
    CMD_SXTB     = 5'd20,
    CMD_UXTH     = 5'd21,
    CMD_UXTB     = 5'd22,
    CMD_SETFLAGS = 5'd23
  } taf_cmd_t;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } taf_shift_t;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } taf_flags_t;

endpackage
`default_nettype wire

// File: hw/rtl/taf_shifter.sv
`default_nettype none
module taf_shifter (
  input  wire taf_pkg::taf_shift_t  kind,
  input  wire logic [31:0]          value,
  input  wire logic [7:0]           amount,
  input  wire logic                 carry_in,
  output logic [31:0]               result,
  output logic                      carry_out
);
  import taf_pkg::*;

  logic [32:0] lsl_w;
  logic [32:0] lsr_w;
  logic [32:0] asr_w;
  logic [63:0] ror_w;
  logic [5:0]  amt_clamp;
  logic        amt_zero;
  logic        amt_over;   // 33 or more
  logic        amt_ge32;

  always_comb begin
    amt_zero  = (amount == 8'd0);
    amt_ge32  = (amount >= 8'd32);
    amt_over  = (amount > 8'd32);
    amt_clamp = amt_ge32 ? 6'd32 : amount[5:0];

    // carry falls out of the extra bit for amounts 1..32
    lsl_w = {1'b0, value} << amt_clamp;
    lsr_w = {value, 1'b0} >> amt_clamp;
    asr_w = 33'($signed({value, 1'b0}) >>> amt_clamp);
    ror_w = {value, value} >> amount[4:0];

    result    = value;
    carry_out = carry_in;
    unique case (kind)
      SH_LSL: begin
        if (amt_over) begin
          result    = '0;
          carry_out = 1'b0;
        end else if (!amt_zero) begin
          result    = lsl_w[31:0];
          carry_out = lsl_w[32];
        end
      end
      SH_LSR: begin
        if (amt_over) begin
          result    = '0;
          carry_out = 1'b0;
        end else if (!amt_zero) begin
          result    = lsr_w[32:1];
          carry_out = lsr_w[0];
        end
      end
      SH_ASR: begin
        if (!amt_zero) begin
          result    = asr_w[32:1];
          carry_out = asr_w[0];
        end
      end
      SH_ROR: begin
        if (!amt_zero) begin
          result    = ror_w[31:0];
          carry_out = ror_w[31];
        end
      end
      default: begin
        result    = value;
        carry_out = carry_in;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/taf_alu.sv
`default_nettype none
module taf_alu (
  input  wire taf_pkg::taf_cmd_t    cmd,
  input  wire logic [31:0]          operand_a,
  input  wire logic [31:0]          operand_b,
  input  wire taf_pkg::taf_flags_t  flags_cur,
  output logic [31:0]               result,
  output taf_pkg::taf_flags_t       flags_new
);
  import taf_pkg::*;

  taf_shift_t  sh_kind;
  logic [31:0] sh_result;
  logic        sh_carry;
  logic [31:0] add_a;
  logic [31:0] add_b;
  logic        add_cin;
  logic [32:0] add_sum;
  logic        add_v;
  logic [31:0] mul_lo;
  logic [15:0] revsh_h;

  assign sh_kind = taf_shift_t'(cmd[1:0]);

  taf_shifter u_shifter (
    .kind      (sh_kind),
    .value     (operand_a),
    .amount    (operand_b[7:0]),
    .carry_in  (flags_cur.c),
    .result    (sh_result),
    .carry_out (sh_carry)
  );

  always_comb begin
    add_a   = operand_a;
    add_b   = operand_b;
    add_cin = 1'b0;
    unique case (cmd)
      CMD_SUB: begin
        add_b   = ~operand_b;
        add_cin = 1'b1;
      end
      CMD_ADC: add_cin = flags_cur.c;
      CMD_SBC: begin
        add_b   = ~operand_b;
        add_cin = flags_cur.c;
      end
      CMD_NEG: begin
        add_a   = '0;
        add_b   = ~operand_a;
        add_cin = 1'b1;
      end
      default: begin
        add_cin = 1'b0;
      end
    endcase
    add_sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
    add_v   = ~(add_a[31] ^ add_b[31]) & (add_a[31] ^ add_sum[31]);
  end

  assign mul_lo  = operand_a * operand_b;
  assign revsh_h = {operand_a[7:0], operand_a[15:8]};

  always_comb begin
    result    = '0;
    flags_new = flags_cur;
    unique case (cmd)
      CMD_LSL, CMD_LSR, CMD_ASR, CMD_ROR: begin
        result      = sh_result;
        flags_new.c = sh_carry;
      end
      CMD_AND: result = operand_a & operand_b;
      CMD_EOR: result = operand_a ^ operand_b;
      CMD_ORR: result = operand_a | operand_b;
      CMD_BIC: result = operand_a & ~operand_b;
      CMD_MVN: result = ~operand_a;
      CMD_MOV: result = operand_a;
      CMD_ADD, CMD_SUB, CMD_ADC, CMD_SBC, CMD_NEG: begin
        result      = add_sum[31:0];
        flags_new.c = add_sum[32];
        flags_new.v = add_v;
      end
      CMD_MUL:   result = mul_lo;
      CMD_REV:   result = {operand_a[7:0], operand_a[15:8],
                           operand_a[23:16], operand_a[31:24]};
      CMD_REV16: result = {operand_a[23:16], operand_a[31:24],
                           operand_a[7:0], operand_a[15:8]};
      CMD_REVSH: result = {{16{revsh_h[15]}}, revsh_h};
      CMD_SXTH:  result = {{16{operand_a[15]}}, operand_a[15:0]};
      CMD_SXTB:  result = {{24{operand_a[7]}}, operand_a[7:0]};
      CMD_UXTH:  result = {16'd0, operand_a[15:0]};
      CMD_UXTB:  result = {24'd0, operand_a[7:0]};
      CMD_SETFLAGS: begin
        result    = '0;
        flags_new = taf_flags_t'(operand_a[31:28]);
      end
      default: begin
        result    = '0;
        flags_new = flags_cur;
      end
    endcase

    // N and Z follow the result for everything up to MUL except the bare extends
    unique case (cmd)
      CMD_LSL, CMD_LSR, CMD_ASR, CMD_ROR, CMD_AND, CMD_EOR, CMD_ORR, CMD_BIC,
      CMD_MVN, CMD_MOV, CMD_ADD, CMD_SUB, CMD_ADC, CMD_SBC, CMD_NEG, CMD_MUL: begin
        flags_new.n = result[31];
        flags_new.z = (result == 32'd0);
      end
      default: begin
        flags_new.n = flags_new.n;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/thumb_alu_flags_unit.sv
`default_nettype none
// Thumb ALU with a kept NZCV flag register.
// An input beat passes the input register, then the result register, to the result beat.
// Throughput: one beat per cycle unless out_tready holds the result; the flag loop is a 4-bit register
// updated as a result is loaded, so back-to-back ADC/SBC see the previous item's carry.
// Reset (rst_n low, synchronous): both stages empty, flags cleared to zero.
module thumb_alu_flags_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [4:0] cmd, [36:5] operand_a, [68:37] operand_b, [71:69] zero
  input  wire logic [taf_pkg::InTdataW-1:0]  in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [31:0] result_value, [32] flag_n, [33] flag_z, [34] flag_c, [35] flag_v, [39:36] zero
  output logic [taf_pkg::OutTdataW-1:0]      out_tdata
);
  import taf_pkg::*;

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  taf_cmd_t    s1_cmd_r;
  logic [31:0] s1_a_r;
  logic [31:0] s1_b_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] out_result_r;
  taf_flags_t  out_flags_r;
  taf_flags_t  flags_r;
  taf_flags_t  flags_nxt;
  logic [31:0] alu_result;
  logic        in_beat;
  logic        out_load;

  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || out_load;
  assign in_beat   = in_tvalid && in_tready;

  taf_alu u_alu (
    .cmd       (s1_cmd_r),
    .operand_a (s1_a_r),
    .operand_b (s1_b_r),
    .flags_cur (flags_r),
    .result    (alu_result),
    .flags_new (flags_nxt)
  );

  always_comb begin
    s1_valid_nxt  = in_beat ? 1'b1 : (out_load ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (out_load) begin
        flags_r <= flags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_cmd_r <= taf_cmd_t'(in_tdata[4:0]);
      s1_a_r   <= in_tdata[36:5];
      s1_b_r   <= in_tdata[68:37];
    end
    if (out_load) begin
      out_result_r <= alu_result;
      out_flags_r  <= flags_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_flags_r.v, out_flags_r.c, out_flags_r.z, out_flags_r.n,
                       out_result_r};

`ifndef SYNTH
  // reported flags are always the kept flags: both load on the same beat
  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_flags_r == flags_r))
    else $error("reported flags differ from kept flags");

  // byte reverse and extend ops leave the flags alone
  a_ext_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (s1_cmd_r == CMD_REV || s1_cmd_r == CMD_REV16 || s1_cmd_r == CMD_REVSH ||
                  s1_cmd_r == CMD_SXTH || s1_cmd_r == CMD_SXTB || s1_cmd_r == CMD_UXTH ||
                  s1_cmd_r == CMD_UXTB)) |=> (flags_r == $past(flags_r)))
    else $error("extend or reverse changed flags");

  // a stalled input stage means a beat is waiting behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without cause");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !s1_valid_r))
    else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import taf_pkg::*;

  localparam int RANDOM_OPS_PER_PHASE = 450;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 10;

  typedef struct packed {
    logic [31:0] value;
    taf_flags_t  flags;
  } alu_result_t;

  typedef struct {
    taf_cmd_t    cmd;
    logic [31:0] opa;
    logic [31:0] opb;
    bit          typed;
    logic [31:0] exp_value;
    logic [3:0]  exp_nzcv;
  } alu_vector_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [InTdataW-1:0]  in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OutTdataW-1:0] out_tdata;

  alu_result_t pending_alu_results[$];
  taf_flags_t  model_flags;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_off_req;
  int          mismatch_count;
  int          stall_cycles;

  // typed rows: value and NZCV read straight off the operation
  alu_vector_t directed_ops [31] = '{
    '{CMD_MOV,      32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 4'b0100},
    '{CMD_SETFLAGS, 32'hF000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 4'b1111},
    '{CMD_LSL,      32'h8000_0001, 32'h0000_0000, 1'b0, 32'h0, 4'h0},
    '{CMD_LSL,      32'h0000_0001, 32'h0000_0020, 1'b0, 32'h0, 4'h0},
    '{CMD_LSL,      32'hFFFF_FFFF, 32'h0000_0021, 1'b0, 32'h0, 4'h0},
    '{CMD_LSR,      32'h8000_0000, 32'h0000_0020, 1'b0, 32'h0, 4'h0},
    '{CMD_LSR,      32'hFFFF_FFFF, 32'h0000_00FF, 1'b0, 32'h0, 4'h0},
    '{CMD_ASR,      32'h8000_0000, 32'h0000_0020, 1'b0, 32'h0, 4'h0},
    '{CMD_ASR,      32'h7FFF_FFFF, 32'h0000_00C8, 1'b0, 32'h0, 4'h0},
    '{CMD_ROR,      32'h8000_0001, 32'h0000_0040, 1'b0, 32'h0, 4'h0},
    '{CMD_ROR,      32'h1234_5678, 32'hFFFF_FF04, 1'b0, 32'h0, 4'h0},
    '{CMD_ROR,      32'h1234_5678, 32'h0000_0000, 1'b0, 32'h0, 4'h0},
    '{CMD_ADD,      32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 32'h8000_0000, 4'b1001},
    '{CMD_ADD,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE, 4'b1010},
    '{CMD_ADC,      32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 4'b0110},
    '{CMD_SUB,      32'h0000_0000, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF, 4'b1000},
    '{CMD_SBC,      32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 4'h0},
    '{CMD_NEG,      32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0, 4'h0},
    '{CMD_MUL,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 4'h0},
    '{CMD_AND,      32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, 4'h0},
    '{CMD_EOR,      32'hA5A5_A5A5, 32'hFFFF_0000, 1'b0, 32'h0, 4'h0},
    '{CMD_ORR,      32'h8000_0000, 32'h0000_0001, 1'b0, 32'h0, 4'h0},
    '{CMD_BIC,      32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, 4'h0},
    '{CMD_MVN,      32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, 4'h0},
    '{CMD_REV,      32'h1234_5678, 32'h0000_0000, 1'b0, 32'h0, 4'h0},
    '{CMD_REV16,    32'hFF00_807F, 32'h0000_0000, 1'b0, 32'h0, 4'h0},
    '{CMD_REVSH,    32'h0000_0080, 32'h0000_0000, 1'b0, 32'h0, 4'h0},
    '{CMD_SXTH,     32'h0000_8000, 32'h0000_0000, 1'b0, 32'h0, 4'h0},
    '{CMD_SXTB,     32'h0000_007F, 32'hFFFF_FFFF, 1'b0, 32'h0, 4'h0},
    '{CMD_UXTH,     32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, 4'h0},
    '{CMD_UXTB,     32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, 4'h0}
  };

  thumb_alu_flags_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advances the kept NZCV copy and returns the value and flags after the op.
  function automatic alu_result_t compute_alu(taf_cmd_t cmd, logic [31:0] a, logic [31:0] b);
    alu_result_t        res;
    int                 amt;
    int                 rot;
    logic [31:0]        r;
    logic [31:0]        add_a;
    logic [31:0]        add_b;
    logic [31:0]        ovf;
    logic [32:0]        wide;
    logic               cin;
    logic signed [31:0] sa;
    bit                 arith;
    bit                 upd_nz;
    amt = int'(b[7:0]);
    r = 32'h0;
    add_a = a;
    add_b = b;
    cin = 1'b0;
    arith = 1'b0;
    upd_nz = 1'b0;
    case (cmd)
      CMD_LSL: begin
        r = a;
        if (amt >= 32) begin
          model_flags.c = (amt == 32) ? a[0] : 1'b0;
          r = 32'h0;
        end else if (amt != 0) begin
          model_flags.c = a[32 - amt];
          r = a << amt;
        end
        upd_nz = 1'b1;
      end
      CMD_LSR: begin
        r = a;
        if (amt >= 32) begin
          model_flags.c = (amt == 32) ? a[31] : 1'b0;
          r = 32'h0;
        end else if (amt != 0) begin
          model_flags.c = a[amt - 1];
          r = a >> amt;
        end
        upd_nz = 1'b1;
      end
      CMD_ASR: begin
        r = a;
        sa = a;
        if (amt >= 32) begin
          r = {32{a[31]}};
          model_flags.c = a[31];
        end else if (amt != 0) begin
          model_flags.c = a[amt - 1];
          r = sa >>> amt;
        end
        upd_nz = 1'b1;
      end
      CMD_ROR: begin
        r = a;
        if (amt != 0) begin
          rot = amt % 32;
          if (rot != 0) r = (a >> rot) | (a << (32 - rot));
          model_flags.c = r[31];
        end
        upd_nz = 1'b1;
      end
      CMD_AND: begin r = a & b;  upd_nz = 1'b1; end
      CMD_EOR: begin r = a ^ b;  upd_nz = 1'b1; end
      CMD_ORR: begin r = a | b;  upd_nz = 1'b1; end
      CMD_BIC: begin r = a & ~b; upd_nz = 1'b1; end
      CMD_MVN: begin r = ~a;     upd_nz = 1'b1; end
      CMD_MOV: begin r = a;      upd_nz = 1'b1; end
      CMD_ADD: arith = 1'b1;
      CMD_SUB: begin add_b = ~b; cin = 1'b1; arith = 1'b1; end
      CMD_ADC: begin cin = model_flags.c; arith = 1'b1; end
      CMD_SBC: begin add_b = ~b; cin = model_flags.c; arith = 1'b1; end
      CMD_NEG: begin add_a = 32'h0; add_b = ~a; cin = 1'b1; arith = 1'b1; end
      CMD_MUL: begin r = a * b;  upd_nz = 1'b1; end
      CMD_REV:   r = {a[7:0], a[15:8], a[23:16], a[31:24]};
      CMD_REV16: r = {a[23:16], a[31:24], a[7:0], a[15:8]};
      CMD_REVSH: r = {{16{a[7]}}, a[7:0], a[15:8]};
      CMD_SXTH:  r = {{16{a[15]}}, a[15:0]};
      CMD_SXTB:  r = {{24{a[7]}}, a[7:0]};
      CMD_UXTH:  r = {16'h0, a[15:0]};
      CMD_UXTB:  r = {24'h0, a[7:0]};
      CMD_SETFLAGS: begin
        model_flags = taf_flags_t'(a[31:28]);
        r = 32'h0;
      end
      default: r = 32'h0;
    endcase
    if (arith) begin
      // carry out of bit 31 is ARM carry, i.e. not-borrow on subtracts
      wide = {1'b0, add_a} + {1'b0, add_b} + {32'h0, cin};
      r = wide[31:0];
      ovf = ~(add_a ^ add_b) & (add_a ^ r);
      model_flags.c = wide[32];
      model_flags.v = ovf[31];
      upd_nz = 1'b1;
    end
    if (upd_nz) begin
      model_flags.n = r[31];
      model_flags.z = (r == 32'h0);
    end
    res.value = r;
    res.flags = model_flags;
    return res;
  endfunction

  // Caller sits at a falling edge; returns at the falling edge after the beat.
  task automatic drive_op(input taf_cmd_t cmd, input logic [31:0] a, input logic [31:0] b,
                          input bit typed, input logic [31:0] exp_value,
                          input logic [3:0] exp_nzcv);
    alu_result_t predicted;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, b, a, cmd};
    do @(posedge clk); while (!in_tready);
    predicted = compute_alu(cmd, a, b);
    if (typed) begin
      predicted.value = exp_value;
      predicted.flags = taf_flags_t'(exp_nzcv);
    end
    pending_alu_results.push_back(predicted);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h0000_0000;
      1: v = 32'hFFFF_FFFF;
      2: v = 32'h8000_0000;
      3: v = 32'h7FFF_FFFF;
      4: v = $urandom_range(0, 3);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic run_random_ops(input int count);
    taf_cmd_t    cmd;
    logic [31:0] a;
    logic [31:0] b;
    for (int i = 0; i < count; i++) begin
      cmd = taf_cmd_t'($urandom_range(0, 23));
      a = pick_operand();
      b = pick_operand();
      // shift amounts cluster around the 0 / 32 boundaries
      if (cmd inside {CMD_LSL, CMD_LSR, CMD_ASR, CMD_ROR} && $urandom_range(0, 3) != 0)
        b[7:0] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(60, 255))
                                              : 8'($urandom_range(0, 34));
      drive_op(cmd, a, b, 1'b0, 32'h0, 4'h0);
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_alu_results.size() != 0) @(negedge clk);
  endtask

  // result side: random tready plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    alu_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_alu_results.size() == 0) begin
        $error("result beat with nothing expected: %h", out_tdata);
        mismatch_count++;
      end else begin
        exp_res = pending_alu_results.pop_front();
        if (out_tdata[31:0] !== exp_res.value) begin
          $error("result_value: expected %h, got %h", exp_res.value, out_tdata[31:0]);
          mismatch_count++;
        end
        if (out_tdata[32] !== exp_res.flags.n) begin
          $error("flag_n: expected %b, got %b", exp_res.flags.n, out_tdata[32]);
          mismatch_count++;
        end
        if (out_tdata[33] !== exp_res.flags.z) begin
          $error("flag_z: expected %b, got %b", exp_res.flags.z, out_tdata[33]);
          mismatch_count++;
        end
        if (out_tdata[34] !== exp_res.flags.c) begin
          $error("flag_c: expected %b, got %b", exp_res.flags.c, out_tdata[34]);
          mismatch_count++;
        end
        if (out_tdata[35] !== exp_res.flags.v) begin
          $error("flag_v: expected %b, got %b", exp_res.flags.v, out_tdata[35]);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    model_flags = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_ops[i])
      drive_op(directed_ops[i].cmd, directed_ops[i].opa, directed_ops[i].opb,
               directed_ops[i].typed, directed_ops[i].exp_value, directed_ops[i].exp_nzcv);
    in_tvalid <= 1'b0;
    wait_drained();

    send_idle_pct = 18;
    recv_idle_pct = 59;
    run_random_ops(RANDOM_OPS_PER_PHASE);
    wait_drained();

    // long result-side hold while beats keep coming
    send_idle_pct = 59;
    recv_idle_pct = 18;
    @(posedge clk);
    hold_off_req = 1'b1;
    @(negedge clk);
    run_random_ops(RANDOM_OPS_PER_PHASE);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_ops(RANDOM_OPS_PER_PHASE);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/taf_pkg.sv
hw/rtl/taf_shifter.sv
hw/rtl/taf_alu.sv
hw/rtl/thumb_alu_flags_unit.sv
bench/tb_top.sv
